// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/hce_pkg.sv
// ----------------------------------------------------------------------------
// hce_pkg
// Types and constants of the Huffman code encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hce_pkg;

   localparam int NUM_SYMBOLS   = 257;
   localparam int MAX_CODE_BITS = 32;
   localparam int SYM_WIDTH     = 9;
   localparam int WORD_WIDTH    = 32;
   localparam int LEN_WIDTH     = 6;
   localparam int COUNT_WIDTH   = 17;
   localparam int ADDR_WIDTH    = 3;
   localparam int DATA_WIDTH    = 32;

   localparam logic [SYM_WIDTH-1:0]   END_SYMBOL     = 9'd256;
   localparam logic [COUNT_WIDTH-1:0] CAPACITY_RESET = 17'h10000;
   localparam logic [LEN_WIDTH-1:0]   MAX_LEN        = LEN_WIDTH'(MAX_CODE_BITS);
   localparam logic [WORD_WIDTH-1:0]  CODE_MASK      =
      WORD_WIDTH'((64'd1 << MAX_CODE_BITS) - 64'd1);

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_ENCODE = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;

   localparam logic REG_OUTPUT_CAPACITY = 1'b0;

   typedef struct packed {
      logic [1:0]            opcode;
      logic [SYM_WIDTH-1:0]  table_symbol;
      logic [WORD_WIDTH-1:0] code_word;
      logic [LEN_WIDTH-1:0]  code_length;
      logic [7:0]            data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]             out_byte;
      logic                   is_final;
      logic                   overflow;
      logic [COUNT_WIDTH-1:0] stream_length;
   } rsp_type;

   typedef struct packed {
      logic [LEN_WIDTH-1:0]  length;
      logic [WORD_WIDTH-1:0] word;
   } entry_type;

   typedef struct packed {
      logic                  en;
      logic [SYM_WIDTH-1:0]  symbol;
      logic [WORD_WIDTH-1:0] word;
      logic [LEN_WIDTH-1:0]  length;
   } tbl_write_type;

endpackage

`default_nettype wire

// File: rtl/huffman_code_encoder.sv
// ----------------------------------------------------------------------------
// huffman_code_encoder
// Huffman encoder over 256 byte symbols plus an end symbol, LSB-first packing.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready, hce_pkg::req_type): load a code entry, encode a
//   data byte, or finish the stream. rsp channel (valid/ready,
//   hce_pkg::rsp_type): packed bytes, then a final flush or overflow result.
//   APB port: register 0 at address 0 is output_capacity.
// Timing:
//   A load is written in the idle state. An encode reads the code table and
//   then runs a byte packer that moves up to eight bits per cycle, plus a
//   closing step. A finish adds a step for the flush byte.
//   Results leave through a one-entry output register; a stalled receiver
//   holds the packer on the step that fills a byte, and req_ready stays low
//   until the request is done.
// Reset:
//   Clears the stream state and output register and sets output_capacity to
//   65536. The code table is not cleared: every symbol that is encoded must
//   be loaded first.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module huffman_code_encoder (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire hce_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output hce_pkg::rsp_type                     rsp_data,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [hce_pkg::ADDR_WIDTH-1:0]  paddr,
   input  wire logic [hce_pkg::DATA_WIDTH-1:0]  pwdata,
   output logic [hce_pkg::DATA_WIDTH-1:0]       prdata,
   output logic                                 pready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_STEP,
      ST_FLUSH
   } state_type;

   state_type                               state_ff,     state_in;
   logic                                    finish_ff,    finish_in;
   logic [hce_pkg::WORD_WIDTH-1:0]          rem_word_ff,  rem_word_in;
   logic [hce_pkg::LEN_WIDTH-1:0]           rem_len_ff,   rem_len_in;
   logic [7:0]                              acc_ff,       acc_in;
   logic [2:0]                              fill_ff,      fill_in;
   logic [hce_pkg::COUNT_WIDTH-1:0]         count_ff,     count_in;
   logic                                    aborted_ff,   aborted_in;
   logic [hce_pkg::COUNT_WIDTH-1:0]         cap_ff,       cap_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   hce_pkg::rsp_type                        rsp_data_ff,  rsp_data_in;

   hce_pkg::tbl_write_type                  tbl_wr;
   logic                                    tbl_rd_en;
   logic [hce_pkg::SYM_WIDTH-1:0]           tbl_rd_symbol;
   hce_pkg::entry_type                      tbl_rd_entry;

   logic                                    req_fire;
   logic                                    out_free;
   logic                                    csr_write;
   logic [3:0]                              space;
   logic [3:0]                              take;
   logic [7:0]                              take_mask;
   logic [7:0]                              chunk;
   logic [7:0]                              acc_next;
   logic [3:0]                              fill_sum;
   logic                                    byte_full;
   logic                                    cap_hit;
   logic [hce_pkg::COUNT_WIDTH-1:0]         count_inc;

   hce_code_table u_table (
      .clock     (clock),
      .wr        (tbl_wr),
      .rd_en     (tbl_rd_en),
      .rd_symbol (tbl_rd_symbol),
      .rd_entry  (tbl_rd_entry)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[2] == hce_pkg::REG_OUTPUT_CAPACITY);
   assign prdata    = (paddr[2] == hce_pkg::REG_OUTPUT_CAPACITY)
                      ? {{(hce_pkg::DATA_WIDTH-hce_pkg::COUNT_WIDTH){1'b0}}, cap_ff}
                      : '0;

   assign tbl_wr.en     = req_fire && (req_data.opcode == hce_pkg::OP_LOAD);
   assign tbl_wr.symbol = req_data.table_symbol;
   assign tbl_wr.word   = req_data.code_word;
   assign tbl_wr.length = req_data.code_length;

   // bit packer step
   always_comb begin
      space     = 4'd8 - {1'b0, fill_ff};
      take      = (rem_len_ff < {2'b00, space}) ? rem_len_ff[3:0] : space;
      take_mask = 8'((9'd1 << take) - 9'd1);
      chunk     = rem_word_ff[7:0] & take_mask;
      acc_next  = acc_ff | 8'(chunk << fill_ff);
      fill_sum  = {1'b0, fill_ff} + take;
      byte_full = fill_sum[3];
      count_inc = count_ff + 17'd1;
      cap_hit   = ({1'b0, count_ff} + 18'd1) >= {1'b0, cap_ff};
   end

   always_comb begin
      state_in      = state_ff;
      finish_in     = finish_ff;
      rem_word_in   = rem_word_ff;
      rem_len_in    = rem_len_ff;
      acc_in        = acc_ff;
      fill_in       = fill_ff;
      count_in      = count_ff;
      aborted_in    = aborted_ff;
      cap_in        = csr_write ? pwdata[hce_pkg::COUNT_WIDTH-1:0] : cap_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      tbl_rd_en     = 1'b0;
      tbl_rd_symbol = {1'b0, req_data.data_byte};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_data.opcode)
                  hce_pkg::OP_ENCODE: begin
                     if (!aborted_ff) begin
                        tbl_rd_en = 1'b1;
                        finish_in = 1'b0;
                        state_in  = ST_READ;
                     end
                  end
                  hce_pkg::OP_FINISH: begin
                     if (aborted_ff) begin
                        acc_in     = '0;
                        fill_in    = '0;
                        count_in   = '0;
                        aborted_in = 1'b0;
                     end else begin
                        tbl_rd_en     = 1'b1;
                        tbl_rd_symbol = hce_pkg::END_SYMBOL;
                        finish_in     = 1'b1;
                        state_in      = ST_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            rem_word_in = tbl_rd_entry.word;
            rem_len_in  = tbl_rd_entry.length;
            state_in    = ST_STEP;
         end
         ST_STEP: begin
            if (rem_len_ff == '0) begin
               state_in = finish_ff ? ST_FLUSH : ST_IDLE;
            end else if (!byte_full) begin
               acc_in      = acc_next;
               fill_in     = fill_sum[2:0];
               rem_word_in = rem_word_ff >> take;
               rem_len_in  = rem_len_ff - {2'b00, take};
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               acc_in       = '0;
               fill_in      = '0;
               rem_word_in  = rem_word_ff >> take;
               rem_len_in   = rem_len_ff - {2'b00, take};
               if (cap_hit) begin
                  rsp_data_in.out_byte      = '0;
                  rsp_data_in.is_final      = 1'b1;
                  rsp_data_in.overflow      = 1'b1;
                  rsp_data_in.stream_length = count_ff;
                  state_in                  = ST_IDLE;
                  if (finish_ff) begin
                     count_in   = '0;
                     aborted_in = 1'b0;
                  end else begin
                     aborted_in = 1'b1;
                  end
               end else begin
                  rsp_data_in.out_byte      = acc_next;
                  rsp_data_in.is_final      = 1'b0;
                  rsp_data_in.overflow      = 1'b0;
                  rsp_data_in.stream_length = '0;
                  count_in                  = count_inc;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.out_byte      = acc_ff;
               rsp_data_in.is_final      = 1'b1;
               rsp_data_in.overflow      = 1'b0;
               rsp_data_in.stream_length = count_inc;
               acc_in                    = '0;
               fill_in                   = '0;
               count_in                  = '0;
               aborted_in                = 1'b0;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         finish_ff    <= 1'b0;
         acc_ff       <= '0;
         fill_ff      <= '0;
         count_ff     <= '0;
         aborted_ff   <= 1'b0;
         cap_ff       <= hce_pkg::CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         finish_ff    <= finish_in;
         acc_ff       <= acc_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         aborted_ff   <= aborted_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_word_ff <= rem_word_in;
      rem_len_ff  <= rem_len_in;
      rsp_data_ff <= rsp_data_in;
   end

   `ASSERT_IMPLIES(a_nonfinal_len_zero, clock, reset,
      rsp_valid_ff && !rsp_data_ff.is_final, rsp_data_ff.stream_length == '0,
      "non-final result carries a stream length")
   `ASSERT_IMPLIES(a_flush_not_aborted, clock, reset,
      state_ff == ST_FLUSH, !aborted_ff,
      "flush entered on an aborted stream")
   `ASSERT_ALWAYS(a_len_bounded, clock, reset,
      rem_len_ff <= hce_pkg::MAX_LEN || state_ff == ST_IDLE || state_ff == ST_READ,
      "remaining code length above maximum")
   `ASSERT_NEXT(a_finish_clears, clock, reset,
      req_fire && req_data.opcode == hce_pkg::OP_FINISH && aborted_ff,
      !aborted_ff && count_ff == '0,
      "finish on aborted stream did not reset it")

endmodule

`default_nettype wire

// File: rtl/hce_code_table.sv
// ----------------------------------------------------------------------------
// hce_code_table
// Code word and length store, one entry per symbol, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hce_code_table (
   input  wire logic                         clock,
   input  wire hce_pkg::tbl_write_type       wr,
   input  wire logic                         rd_en,
   input  wire logic [hce_pkg::SYM_WIDTH-1:0] rd_symbol,
   output hce_pkg::entry_type                rd_entry
);

   hce_pkg::entry_type mem [hce_pkg::NUM_SYMBOLS];
   hce_pkg::entry_type wr_entry;
   logic               wr_ok;

   always_comb begin
      wr_ok           = wr.en && (32'(wr.symbol) < 32'(hce_pkg::NUM_SYMBOLS));
      wr_entry.word   = wr.word & hce_pkg::CODE_MASK;
      wr_entry.length = (wr.length > hce_pkg::MAX_LEN) ? hce_pkg::MAX_LEN : wr.length;
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[wr.symbol] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry <= mem[rd_symbol];
      end
   end

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds the Huffman code encoder with code loads, data bytes and stream
// finishes under a sweep of output capacities. Random stalls are applied on
// both channels. A scoreboard keeps its own copy of the code table and the bit
// packer, and checks every packed byte, flush and overflow abort in order.
// ----------------------------------------------------------------------------

class code_stream_scoreboard;
   hce_pkg::entry_type              codes [hce_pkg::NUM_SYMBOLS];
   logic [7:0]                      acc;
   logic [2:0]                      fill;
   logic [hce_pkg::COUNT_WIDTH-1:0] sent;
   bit                              dead;
   logic [hce_pkg::COUNT_WIDTH-1:0] capacity;
   hce_pkg::rsp_type                owed [$];

   function new();
      capacity = hce_pkg::CAPACITY_RESET;
      clear_stream();
   endfunction

   function void clear_stream();
      acc  = '0;
      fill = '0;
      sent = '0;
      dead = 0;
   endfunction

   function void push(logic [7:0] b, logic fin, logic ovf,
                      logic [hce_pkg::COUNT_WIDTH-1:0] len);
      hce_pkg::rsp_type r;
      r.out_byte      = b;
      r.is_final      = fin;
      r.overflow      = ovf;
      r.stream_length = len;
      owed.push_back(r);
   endfunction

   function void append_code(logic [hce_pkg::SYM_WIDTH-1:0] sym);
      hce_pkg::entry_type e;
      e = codes[sym];
      for (int i = 0; i < e.length && !dead; i++) begin
         acc[fill] = e.word[i];
         if (fill == 3'd7) begin
            if (int'(sent) + 1 >= int'(capacity)) begin
               push(8'h00, 1'b1, 1'b1, sent);
               dead = 1;
            end else begin
               push(acc, 1'b0, 1'b0, '0);
               sent = sent + 1'b1;
            end
            acc  = '0;
            fill = '0;
         end else begin
            fill = fill + 1'b1;
         end
      end
   endfunction

   function void note_request(hce_pkg::req_type q);
      logic [hce_pkg::LEN_WIDTH-1:0] len;
      case (q.opcode)
         hce_pkg::OP_LOAD: begin
            if (q.table_symbol < hce_pkg::NUM_SYMBOLS) begin
               len = (q.code_length > hce_pkg::MAX_LEN) ? hce_pkg::MAX_LEN : q.code_length;
               codes[q.table_symbol].length = len;
               codes[q.table_symbol].word   = q.code_word & hce_pkg::CODE_MASK;
            end
         end
         hce_pkg::OP_ENCODE: begin
            if (!dead) append_code({1'b0, q.data_byte});
         end
         hce_pkg::OP_FINISH: begin
            if (!dead) begin
               append_code(hce_pkg::END_SYMBOL);
               if (!dead) begin
                  sent = sent + 1'b1;
                  push(acc, 1'b1, 1'b0, sent);
               end
            end
            clear_stream();
         end
         default: ;
      endcase
   endfunction

   function string check_output(hce_pkg::rsp_type got);
      hce_pkg::rsp_type want;
      string            why;
      if (owed.size() == 0)
         return $sformatf(" unexpected output byte %02h final %0b overflow %0b length %0d",
                          got.out_byte, got.is_final, got.overflow, got.stream_length);
      want = owed.pop_front();
      why  = "";
      if (got.out_byte !== want.out_byte)
         why = {why, $sformatf(" out_byte %02h want %02h", got.out_byte, want.out_byte)};
      if (got.is_final !== want.is_final)
         why = {why, $sformatf(" is_final %0b want %0b", got.is_final, want.is_final)};
      if (got.overflow !== want.overflow)
         why = {why, $sformatf(" overflow %0b want %0b", got.overflow, want.overflow)};
      if (got.stream_length !== want.stream_length)
         why = {why, $sformatf(" stream_length %0d want %0d",
                               got.stream_length, want.stream_length)};
      return why;
   endfunction
endclass

module testbench;
   localparam logic [1:0] OP_SPARE      = 2'd3;
   localparam int         CYCLE_LIMIT   = 600000;
   localparam int         SETTLE_CYCLES = 24;
   localparam int         PHASES        = 9;
   localparam int         PHASE_BUDGET  = 30;
   localparam logic [hce_pkg::ADDR_WIDTH-1:0] CAPACITY_ADDR =
      {hce_pkg::REG_OUTPUT_CAPACITY, 2'b00};

   logic                            clock;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   hce_pkg::req_type                req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   hce_pkg::rsp_type                rsp_data;
   logic                            psel      = 1'b0;
   logic                            penable   = 1'b0;
   logic                            pwrite    = 1'b0;
   logic [hce_pkg::ADDR_WIDTH-1:0]  paddr     = '0;
   logic [hce_pkg::DATA_WIDTH-1:0]  pwdata    = '0;
   logic [hce_pkg::DATA_WIDTH-1:0]  prdata;
   logic                            pready;

   code_stream_scoreboard           board;
   int                              send_idle = 23;
   int                              recv_idle = 68;
   int                              errors    = 0;
   int                              outputs   = 0;
   int                              overflows = 0;
   int                              flushes   = 0;
   int                              requests  = 0;
   int                              cycles    = 0;
   bit                              byte_loaded [256];
   int                              loaded_bytes [$];
   logic [hce_pkg::COUNT_WIDTH-1:0] capacities [PHASES] = '{17'h10000, 17'd9, 17'd1,
                                                            17'h1FFFF, 17'd4, 17'd0,
                                                            17'd30, 17'd2, 17'h10000};

   huffman_code_encoder dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d outputs still owed", cycles, board.owed.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic log_mismatch(string why);
      if (why != "") begin
         errors++;
         if (errors <= 50) $display("[%0t] mismatch at output %0d:%s", $time, outputs, why);
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            outputs++;
            if (rsp_data.overflow) overflows++;
            else if (rsp_data.is_final) flushes++;
            log_mismatch(board.check_output(rsp_data));
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   function automatic hce_pkg::req_type make_request(logic [1:0] op);
      hce_pkg::req_type q;
      q.opcode       = op;
      q.table_symbol = hce_pkg::SYM_WIDTH'($urandom);
      q.code_word    = $urandom;
      q.code_length  = hce_pkg::LEN_WIDTH'($urandom);
      q.data_byte    = 8'($urandom);
      return q;
   endfunction

   task automatic send(hce_pkg::req_type q);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (!req_ready);
      board.note_request(q);
      requests++;
   endtask

   task automatic send_load(logic [hce_pkg::SYM_WIDTH-1:0] sym,
                            logic [hce_pkg::WORD_WIDTH-1:0] word,
                            logic [hce_pkg::LEN_WIDTH-1:0] len);
      hce_pkg::req_type q;
      q              = make_request(hce_pkg::OP_LOAD);
      q.table_symbol = sym;
      q.code_word    = word;
      q.code_length  = len;
      if (sym < 256 && !byte_loaded[sym]) begin
         byte_loaded[sym] = 1;
         loaded_bytes.push_back(sym);
      end
      send(q);
   endtask

   task automatic send_encode(logic [7:0] b);
      hce_pkg::req_type q;
      q           = make_request(hce_pkg::OP_ENCODE);
      q.data_byte = b;
      send(q);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (board.owed.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_capacity(logic [hce_pkg::COUNT_WIDTH-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CAPACITY_ADDR;
      pwdata  <= hce_pkg::DATA_WIDTH'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.capacity = value;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== hce_pkg::DATA_WIDTH'(value))
         log_mismatch($sformatf(" capacity reads %0d want %0d", prdata, value));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // mostly whole streams ending in a finish, with noise and stray loads mixed in
   task automatic run_streams(int budget);
      int         counted;
      int         n;
      int         pick;
      int         len_pick;
      logic [7:0] b;
      counted = 0;
      while (counted < budget) begin
         n = $urandom_range(12);
         for (int k = 0; k < n; k++) begin
            pick     = $urandom_range(99);
            len_pick = $urandom_range(9);
            if (pick < 15) begin
               if ($urandom_range(9) == 0) begin
                  send_load(hce_pkg::SYM_WIDTH'($urandom_range(511, hce_pkg::NUM_SYMBOLS)),
                            $urandom, hce_pkg::LEN_WIDTH'($urandom));
               end else begin
                  send_load(hce_pkg::SYM_WIDTH'($urandom_range(hce_pkg::NUM_SYMBOLS - 1)),
                            $urandom,
                            hce_pkg::LEN_WIDTH'(len_pick < 7 ? $urandom_range(1, 12) :
                                                len_pick < 9 ? $urandom_range(0, 32) :
                                                $urandom_range(33, 63)));
                  counted++;
               end
            end else if (pick < 22) begin
               send(make_request(OP_SPARE));
            end else begin
               b = 8'($urandom_range(255));
               if (!byte_loaded[b]) b = 8'(loaded_bytes[$urandom_range(loaded_bytes.size() - 1)]);
               send_encode(b);
               counted++;
            end
         end
         if ($urandom_range(9) != 0) begin
            send(make_request(hce_pkg::OP_FINISH));
            counted++;
         end
      end
   endtask

   initial begin
      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty end code on an empty stream: a lone zero flush byte
      send_load(hce_pkg::END_SYMBOL, $urandom, 6'd0);
      send(make_request(hce_pkg::OP_FINISH));
      send_load(9'd0, $urandom, 6'd0);
      send_load(9'd255, 32'hFFFF_FFFF, 6'd32);
      send_load(9'd1, 32'h5A5A_A5A5, 6'd63);
      send_load(9'd2, 32'h0000_0001, 6'd1);
      send_load(9'd3, 32'h0000_0096, 6'd8);
      send_load(9'd511, $urandom, 6'd7);
      send_load(9'd257, $urandom, 6'd5);
      send(make_request(OP_SPARE));
      send_encode(8'd0);
      send_encode(8'd255);
      send_encode(8'd1);
      send_encode(8'd3);
      send_encode(8'd2);
      send(make_request(hce_pkg::OP_FINISH));
      // byte-aligned finish
      send_load(hce_pkg::END_SYMBOL, $urandom, 6'd8);
      send_encode(8'd3);
      send(make_request(hce_pkg::OP_FINISH));
      settle();

      // overflow on encode, aborted stream, then overflow inside the finish
      program_capacity(17'd2);
      send_encode(8'd255);
      send_encode(8'd3);
      send(make_request(hce_pkg::OP_FINISH));
      send_load(hce_pkg::END_SYMBOL, $urandom, 6'd13);
      send_encode(8'd3);
      send(make_request(hce_pkg::OP_FINISH));

      for (int p = 0; p < PHASES; p++) begin
         case (p / 3)
            0: begin
               send_idle = 23;
               recv_idle = 68;
            end
            1: begin
               send_idle = 68;
               recv_idle = 23;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         settle();
         program_capacity(capacities[p]);
         run_streams(PHASE_BUDGET);
      end
      settle();

      $display("ran %0d requests over %0d capacity settings, %0d outputs checked",
               requests, PHASES + 1, outputs);
      $display("streams closed by flush: %0d, aborted by overflow: %0d", flushes, overflows);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
